// ===== rtl/bilinear_pixel_scaler_assert.svh =====
// Assertion macros for the bilinear pixel scaler.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef BILINEAR_PIXEL_SCALER_ASSERT_SVH
`define BILINEAR_PIXEL_SCALER_ASSERT_SVH

// The condition on the right must hold in the same cycle as the one on the left.
`define BPS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition on the right must hold in the cycle after the one on the left.
`define BPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/bps_pkg.sv =====
// Shared types and constants of the bilinear pixel scaler.
// No dependencies; every RTL module imports this package.
`default_nettype none

package bps_pkg;

	localparam int FRAC_W = 16;
	localparam int STEP_W = 24;
	localparam int CH_W   = 8;
	localparam int LANES  = 4;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_SMOOTH       = 3'd0;
	localparam logic [2:0] REG_PIXEL_FORMAT = 3'd1;
	localparam logic [2:0] REG_STEP_X       = 3'd2;
	localparam logic [2:0] REG_STEP_Y       = 3'd3;
	localparam logic [2:0] REG_ROW_WIDTH    = 3'd4;
	localparam logic [2:0] REG_START_X      = 3'd5;
	localparam logic [2:0] REG_START_Y      = 3'd6;

	// Pixel format codes.
	localparam logic FMT_RGBA8888 = 1'b0;
	localparam logic FMT_RGB565   = 1'b1;

	// Channel masks.
	localparam logic [CH_W-1:0] MASK5 = 8'h1f;
	localparam logic [CH_W-1:0] MASK6 = 8'h3f;
	localparam logic [CH_W-1:0] MASK8 = 8'hff;

	localparam logic [STEP_W-1:0] STEP_RESET = 24'h010000;

	typedef struct packed {
		logic              smooth;
		logic              pixel_format;
		logic [STEP_W-1:0] step_x;
		logic [STEP_W-1:0] step_y;
		logic [12:0]       row_width;
		logic [11:0]       start_x;
		logic [11:0]       start_y;
	} cfg_t;

	typedef struct packed {
		logic [7:0] col_advance;
		logic       row_end;
		logic [7:0] row_advance;
	} pos_info_t;

endpackage

`default_nettype wire

// ===== rtl/bilinear_pixel_scaler.sv =====
// Bilinear pixel scaler, top level. Pipeline: stage 1 register, two lane stages and the
// output register. Throughput: one item per cycle while the output is not held back; the
// input also pauses in the cycle after each configuration write and after reset.
// Reset (asynchronous, active low) loads the register defaults, zeroes the positions
// and empties the pipeline. Depends on bps_pkg, bps_pos, bps_lane, bps_merge.
`default_nettype none
`include "bilinear_pixel_scaler_assert.svh"

module bilinear_pixel_scaler #(
	parameter int MAX_ROW_WIDTH = 4096
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Input items.
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// [31:0] pix_top_left, [63:32] pix_top_right,
	// [95:64] pix_bottom_left, [127:96] pix_bottom_right
	input  wire logic [127:0] s_axis_tdata,
	// [0] frame_start
	input  wire logic [0:0]   s_axis_tuser,
	// Result items.
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [31:0] out_pixel, [39:32] col_advance, [47:40] row_advance
	output logic [47:0]       m_axis_tdata,
	// row_end
	output logic              m_axis_tlast,
	// Configuration writes.
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [23:0]  cfg_data
);
	import bps_pkg::*;

	// Configuration registers. Writes are always taken; an index beyond the
	// register list is simply dropped.
	cfg_t cfg_q;
	logic cfg_write;
	logic cfg_dirty_q;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.smooth       <= 1'b1;
			cfg_q.pixel_format <= FMT_RGBA8888;
			cfg_q.step_x       <= STEP_RESET;
			cfg_q.step_y       <= STEP_RESET;
			cfg_q.row_width    <= 13'd1;
			cfg_q.start_x      <= '0;
			cfg_q.start_y      <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SMOOTH:       cfg_q.smooth       <= cfg_data[0];
				REG_PIXEL_FORMAT: cfg_q.pixel_format <= cfg_data[0];
				REG_STEP_X:       cfg_q.step_x       <= cfg_data;
				REG_STEP_Y:       cfg_q.step_y       <= cfg_data;
				REG_ROW_WIDTH:    cfg_q.row_width    <= cfg_data[12:0];
				REG_START_X:      cfg_q.start_x      <= cfg_data[11:0];
				REG_START_Y:      cfg_q.start_y      <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	// The start offsets in the position tracker are registered products of the
	// configuration, so they trail a write until their register has loaded. The input
	// holds off while they trail, and for the first cycle after reset for the same reason.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_dirty_q <= 1'b1;
		end else begin
			cfg_dirty_q <= cfg_write;
		end
	end

	// The whole pipeline moves together; it freezes only while a result waits
	// at the output and the downstream side is not taking it.
	logic en;
	logic accept;

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en && !cfg_dirty_q;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Position tracking happens in the cycle of acceptance, so the next item
	// always sees the positions left by this one.
	logic [FRAC_W-1:0] fx_cur, fy_cur;
	pos_info_t         info_cur;

	bps_pos #(
		.MAX_ROW_WIDTH(MAX_ROW_WIDTH)
	) u_pos (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.frame_start(s_axis_tuser[0]),
		.cfg        (cfg_q),
		.fx         (fx_cur),
		.fy         (fy_cur),
		.info       (info_cur)
	);

	// Stage 1: the four neighbours, the positions and the advances.
	logic              v_s1, v_s2, v_s3;
	logic [31:0]       c00_s1, c01_s1, c10_s1, c11_s1;
	logic [FRAC_W-1:0] fx_s1, fy_s1;
	pos_info_t         info_s1, info_s2, info_s3;
	logic [31:0]       c00_s2, c00_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c00_s1  <= s_axis_tdata[31:0];
			c01_s1  <= s_axis_tdata[63:32];
			c10_s1  <= s_axis_tdata[95:64];
			c11_s1  <= s_axis_tdata[127:96];
			fx_s1   <= fx_cur;
			fy_s1   <= fy_cur;
			info_s1 <= info_cur;
			info_s2 <= info_s1;
			info_s3 <= info_s2;
			c00_s2  <= c00_s1;
			c00_s3  <= c00_s2;
		end
	end

	// Channel split. In RGBA8888 each lane takes one byte. In RGB565 lane 0
	// carries blue, lane 1 green and lane 2 red, each zero-extended to a byte
	// and masked back to its own width; lane 3 idles.
	function automatic logic [CH_W-1:0] chan(input logic [31:0] p, input logic [1:0] lane,
			input logic fmt);
		logic [CH_W-1:0] v;
		if (fmt == FMT_RGBA8888) begin
			v = p[{lane, 3'b000} +: CH_W];
		end else begin
			case (lane)
				2'd0:    v = {3'b000, p[4:0]};
				2'd1:    v = {2'b00, p[10:5]};
				2'd2:    v = {3'b000, p[15:11]};
				default: v = '0;
			endcase
		end
		return v;
	endfunction

	function automatic logic [CH_W-1:0] chan_mask(input logic [1:0] lane, input logic fmt);
		logic [CH_W-1:0] m;
		if (fmt == FMT_RGBA8888) begin
			m = MASK8;
		end else begin
			case (lane)
				2'd0:    m = MASK5;
				2'd1:    m = MASK6;
				2'd2:    m = MASK5;
				default: m = '0;
			endcase
		end
		return m;
	endfunction

	// Stages 2 and 3 live inside the lanes.
	logic [LANES-1:0][CH_W-1:0] lane_res;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		bps_lane u_lane (
			.clk   (clk),
			.en    (en),
			.mask  (chan_mask(2'(i), cfg_q.pixel_format)),
			.c00   (chan(c00_s1, 2'(i), cfg_q.pixel_format)),
			.c01   (chan(c01_s1, 2'(i), cfg_q.pixel_format)),
			.c10   (chan(c10_s1, 2'(i), cfg_q.pixel_format)),
			.c11   (chan(c11_s1, 2'(i), cfg_q.pixel_format)),
			.fx    (fx_s1),
			.fy    (fy_s1),
			.res_s3(lane_res[i])
		);
	end

	// Stage 4: build the pixel (lanes, or c00 unsmoothed) and hold the result item.
	bps_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_s3(v_s3),
		.cfg     (cfg_q),
		.c00_s3  (c00_s3),
		.lane_res(lane_res),
		.info_s3 (info_s3),
		.tvalid  (m_axis_tvalid),
		.tdata   (m_axis_tdata),
		.tlast   (m_axis_tlast)
	);

	// A configuration write blocks the input for the following cycle.
	`BPS_ASSERT_NEXT(a_cfg_holds_input, cfg_write, !s_axis_tready, "input taken after a write")
	// A frozen pipeline keeps its first stage.
	`BPS_ASSERT_NEXT(a_stall_keeps_s1, v_s1 && !en, v_s1, "item lost from stage 1")
	// A new result only ever comes out of the last lane stage.
	`BPS_ASSERT_SAME(a_out_from_s3, $rose(m_axis_tvalid), $past(v_s3), "result without item")
	// The row advance is zero unless the item closes a row.
	`BPS_ASSERT_SAME(a_row_adv_zero, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[47:40] == 8'h00, "row advance set")

endmodule

`default_nettype wire

// ===== rtl/bps_pos.sv =====
// Position tracker: fractional x and y positions, column count and advances.
// Depends on bps_pkg.
`default_nettype none

module bps_pos #(
	parameter int MAX_ROW_WIDTH = 4096
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      accept,
	input  wire logic                      frame_start,
	input  wire bps_pkg::cfg_t             cfg,
	output logic [bps_pkg::FRAC_W-1:0]     fx,
	output logic [bps_pkg::FRAC_W-1:0]     fy,
	output bps_pkg::pos_info_t             info
);
	import bps_pkg::*;

	localparam int CNT_W = $clog2(MAX_ROW_WIDTH);
	localparam int WW    = (CNT_W + 1 > 13) ? CNT_W + 1 : 13;

	logic [FRAC_W-1:0] frac_x_q, frac_y_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [FRAC_W-1:0] first_fx_q, first_fy_q;

	logic [27:0]       prod_fx, prod_fy;
	logic [CNT_W-1:0]  cnt_cur;
	logic [CNT_W:0]    cnt_inc;
	logic [STEP_W:0]   sum_x, sum_y;
	logic [WW-1:0]     rw_ext, width_eff;
	logic              row_end;

	// Start offsets, kept registered; only the low 16 bits matter.
	assign prod_fx = {16'b0, cfg.start_x} * {12'b0, cfg.step_x[FRAC_W-1:0]};
	assign prod_fy = {16'b0, cfg.start_y} * {12'b0, cfg.step_y[FRAC_W-1:0]};

	always_ff @(posedge clk) begin
		first_fx_q <= prod_fx[FRAC_W-1:0];
		first_fy_q <= prod_fy[FRAC_W-1:0];
	end

	always_comb begin
		fx      = frame_start ? first_fx_q : frac_x_q;
		fy      = frame_start ? first_fy_q : frac_y_q;
		cnt_cur = frame_start ? '0 : cnt_q;
		cnt_inc = {1'b0, cnt_cur} + (CNT_W+1)'(1);
		sum_x   = {{(STEP_W+1-FRAC_W){1'b0}}, fx} + {1'b0, cfg.step_x};
		sum_y   = {{(STEP_W+1-FRAC_W){1'b0}}, fy} + {1'b0, cfg.step_y};
		rw_ext  = WW'(cfg.row_width);
		if (rw_ext == '0) begin
			width_eff = WW'(1);
		end else if (rw_ext > WW'(MAX_ROW_WIDTH)) begin
			width_eff = WW'(MAX_ROW_WIDTH);
		end else begin
			width_eff = rw_ext;
		end
		row_end          = WW'(cnt_inc) >= width_eff;
		info.col_advance = sum_x[FRAC_W+7:FRAC_W];
		info.row_end     = row_end;
		info.row_advance = row_end ? sum_y[FRAC_W+7:FRAC_W] : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_x_q <= '0;
			frac_y_q <= '0;
			cnt_q    <= '0;
		end else if (accept) begin
			if (row_end) begin
				frac_x_q <= first_fx_q;
				frac_y_q <= sum_y[FRAC_W-1:0];
				cnt_q    <= '0;
			end else begin
				frac_x_q <= sum_x[FRAC_W-1:0];
				frac_y_q <= fy;
				cnt_q    <= cnt_inc[CNT_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bps_lane.sv =====
// One interpolation lane: horizontal blends, then the vertical blend.
// Depends on bps_pkg.
`default_nettype none

module bps_lane (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [bps_pkg::CH_W-1:0]  mask,
	input  wire logic [bps_pkg::CH_W-1:0]  c00,
	input  wire logic [bps_pkg::CH_W-1:0]  c01,
	input  wire logic [bps_pkg::CH_W-1:0]  c10,
	input  wire logic [bps_pkg::CH_W-1:0]  c11,
	input  wire logic [bps_pkg::FRAC_W-1:0] fx,
	input  wire logic [bps_pkg::FRAC_W-1:0] fy,
	output logic [bps_pkg::CH_W-1:0]       res_s3
);
	import bps_pkg::*;

	// a + floor((b - a) * f / 65536), kept to the low bits.
	function automatic logic [CH_W-1:0] mix(input logic [CH_W-1:0] a,
			input logic [CH_W-1:0] b, input logic [FRAC_W-1:0] f);
		logic signed [CH_W:0]          diff;
		logic signed [CH_W+FRAC_W+1:0] prod;
		diff = $signed({1'b0, b}) - $signed({1'b0, a});
		prod = diff * $signed({1'b0, f});
		return a + prod[FRAC_W+CH_W-1:FRAC_W];
	endfunction

	logic [CH_W-1:0]   t1_s2, t2_s2;
	logic [FRAC_W-1:0] fy_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			t1_s2  <= mix(c00, c01, fx) & mask;
			t2_s2  <= mix(c10, c11, fx) & mask;
			fy_s2  <= fy;
			res_s3 <= mix(t1_s2, t2_s2, fy_s2) & mask;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bps_merge.sv =====
// Output stage: builds the pixel from the lanes or c00_s3; holds the result.
// Depends on bps_pkg.
`default_nettype none

module bps_merge (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   en,
	input  wire logic                                   valid_s3,
	input  wire bps_pkg::cfg_t                          cfg,
	input  wire logic [31:0]                            c00_s3,
	input  wire logic [bps_pkg::LANES-1:0][bps_pkg::CH_W-1:0] lane_res,
	input  wire bps_pkg::pos_info_t                     info_s3,
	output logic                                        tvalid,
	output logic [47:0]                                 tdata,
	output logic                                        tlast
);
	import bps_pkg::*;

	logic [31:0] pixel;

	always_comb begin
		if (cfg.pixel_format == FMT_RGB565) begin
			if (cfg.smooth) begin
				pixel = {16'h0000, lane_res[2][4:0], lane_res[1][5:0], lane_res[0][4:0]};
			end else begin
				pixel = {16'h0000, c00_s3[15:0]};
			end
		end else begin
			pixel = cfg.smooth ? lane_res : c00_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid <= 1'b0;
		end else if (en) begin
			tvalid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tdata <= {info_s3.row_advance, info_s3.col_advance, pixel};
			tlast <= info_s3.row_end;
		end
	end

endmodule

`default_nettype wire

// ===== sim/bilinear_pixel_scaler_test.sv =====
// Self-checking testbench for the bilinear pixel scaler top level.
// Depends on bps_pkg and bilinear_pixel_scaler; drives directed and random neighbour items
// and register settings and checks every result item against a cycle-free model of the scaler.
`default_nettype none

module bilinear_pixel_scaler_test;

	import bps_pkg::*;

	localparam int RESULT_LATENCY = 3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 64;
	localparam int ROW_LIMIT      = 4096;
	// Index that names no register; a write to it must change nothing.
	localparam logic [2:0] REG_UNUSED = 3'd7;

	// One input item: the four source neighbours and the frame restart flag.
	typedef struct {
		logic        frame_start;
		logic [31:0] top_left;
		logic [31:0] top_right;
		logic [31:0] bottom_left;
		logic [31:0] bottom_right;
	} neighbours_t;

	// One result item as the scaler should present it.
	typedef struct {
		logic [31:0] pixel;
		logic [7:0]  col_advance;
		logic        row_end;
		logic [7:0]  row_advance;
	} scaled_pixel_t;

	logic         clk           = 1'b0;
	logic         arst_n        = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata  = '0;
	logic [0:0]   s_axis_tuser  = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [47:0]  m_axis_tdata;
	logic         m_axis_tlast;
	logic         cfg_valid     = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index     = '0;
	logic [23:0]  cfg_data      = '0;

	bilinear_pixel_scaler dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #1 clk = ~clk;

	// Items waiting to be offered, and results the scaler still owes us.
	neighbours_t   pixels_to_send[$];
	scaled_pixel_t expected_pixels[$];

	// Mirror of the register file and of the scan position.
	cfg_t        model_cfg;
	logic [15:0] model_frac_x;
	logic [15:0] model_frac_y;
	int          model_columns;

	// Handshake bookkeeping of the clocked processes, partly shared between them.
	bit pixel_taken;
	bit bursts_on;
	bit hold_request;
	int send_gap;
	int recv_gap;
	int hold_left;
	int stall_cycles;

	int error_count;
	int items_taken;
	int results_checked;
	int row_ends_seen;
	int settings_used;

	// ------------------------------------------------------------------
	// Model of the scaler.
	// ------------------------------------------------------------------

	// One-dimensional interpolation step on a single channel. The product is signed, and
	// the arithmetic shift floors it toward minus infinity, which is what the hardware does.
	function automatic logic [7:0] blend_channel(input logic [7:0] a, input logic [7:0] b,
			input logic [15:0] frac, input logic [7:0] mask);
		int diff;
		diff = (int'(b) - int'(a)) * int'(frac);
		return 8'(int'(a) + (diff >>> 16)) & mask;
	endfunction

	// Two horizontal blends across the top and bottom pairs, then one vertical blend.
	function automatic logic [7:0] bilerp_channel(input logic [7:0] c00, input logic [7:0] c01,
			input logic [7:0] c10, input logic [7:0] c11, input logic [7:0] mask);
		logic [7:0] upper;
		logic [7:0] lower;
		upper = blend_channel(c00, c01, model_frac_x, mask);
		lower = blend_channel(c10, c11, model_frac_x, mask);
		return blend_channel(upper, lower, model_frac_y, mask);
	endfunction

	// Fractional x position at the first column of every row.
	function automatic logic [15:0] row_start_frac();
		logic [35:0] product;
		product = 36'(model_cfg.start_x) * 36'(model_cfg.step_x);
		return product[15:0];
	endfunction

	// Works out the result for one taken item and advances the scan position.
	function automatic scaled_pixel_t scale_pixel(input neighbours_t nb);
		scaled_pixel_t res;
		logic [35:0]   product;
		logic [24:0]   sum;
		logic [7:0]    red;
		logic [7:0]    green;
		logic [7:0]    blue;
		int            width;
		res = '{default: '0};
		if (nb.frame_start) begin
			model_frac_x = row_start_frac();
			product = 36'(model_cfg.start_y) * 36'(model_cfg.step_y);
			model_frac_y = product[15:0];
			model_columns = 0;
		end

		if (model_cfg.pixel_format == FMT_RGB565) begin
			// The neighbours' upper halves are ignored and the result's upper half is zero.
			if (model_cfg.smooth) begin
				red = bilerp_channel(8'(nb.top_left[15:11]), 8'(nb.top_right[15:11]),
					8'(nb.bottom_left[15:11]), 8'(nb.bottom_right[15:11]), MASK5);
				green = bilerp_channel(8'(nb.top_left[10:5]), 8'(nb.top_right[10:5]),
					8'(nb.bottom_left[10:5]), 8'(nb.bottom_right[10:5]), MASK6);
				blue = bilerp_channel(8'(nb.top_left[4:0]), 8'(nb.top_right[4:0]),
					8'(nb.bottom_left[4:0]), 8'(nb.bottom_right[4:0]), MASK5);
				res.pixel = {16'h0000, red[4:0], green[5:0], blue[4:0]};
			end else begin
				res.pixel = {16'h0000, nb.top_left[15:0]};
			end
		end else begin
			if (model_cfg.smooth) begin
				for (int lane = 0; lane < LANES; lane++) begin
					res.pixel[lane*8 +: 8] = bilerp_channel(nb.top_left[lane*8 +: 8],
						nb.top_right[lane*8 +: 8], nb.bottom_left[lane*8 +: 8],
						nb.bottom_right[lane*8 +: 8], MASK8);
				end
			end else begin
				res.pixel = nb.top_left;
			end
		end

		// The column advance keeps only eight bits of the integer part.
		sum = 25'(model_frac_x) + 25'(model_cfg.step_x);
		res.col_advance = sum[23:16];
		model_frac_x = sum[15:0];

		// A row width of zero behaves as one; anything wider than the limit saturates.
		width = int'(model_cfg.row_width);
		if (width == 0)
			width = 1;
		if (width > ROW_LIMIT)
			width = ROW_LIMIT;

		model_columns++;
		if (model_columns >= width) begin
			sum = 25'(model_frac_y) + 25'(model_cfg.step_y);
			res.row_end = 1'b1;
			res.row_advance = sum[23:16];
			model_frac_y = sum[15:0];
			model_columns = 0;
			model_frac_x = row_start_frac();
		end
		return res;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			error_count++;
		end
	endtask

	// ------------------------------------------------------------------
	// Sampling at the rising edge: checks results, predicts for taken items and
	// follows register writes. Everything is read before the scaler's own updates land.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		scaled_pixel_t want;
		neighbours_t   nb;
		bit            result_taken;
		bit            reg_written;
		if (!arst_n) begin
			model_cfg.smooth       = 1'b1;
			model_cfg.pixel_format = FMT_RGBA8888;
			model_cfg.step_x       = STEP_RESET;
			model_cfg.step_y       = STEP_RESET;
			model_cfg.row_width    = 13'd1;
			model_cfg.start_x      = '0;
			model_cfg.start_y      = '0;
			model_frac_x  = '0;
			model_frac_y  = '0;
			model_columns = 0;
			pixel_taken   = 1'b0;
			stall_cycles  = 0;
		end else begin
			pixel_taken  = s_axis_tvalid && s_axis_tready;
			result_taken = m_axis_tvalid && m_axis_tready;
			reg_written  = cfg_valid && cfg_ready;

			// A result can never belong to an item taken at this same edge, so the
			// oldest expectation is consumed before the new one is queued.
			if (result_taken) begin
				if (expected_pixels.size() == 0) begin
					$error("result item with no expectation waiting: tdata 0x%0h tlast %0b",
						m_axis_tdata, m_axis_tlast);
					error_count++;
				end else begin
					want = expected_pixels.pop_front();
					compare_field("out_pixel", want.pixel, m_axis_tdata[31:0]);
					compare_field("col_advance", 32'(want.col_advance), 32'(m_axis_tdata[39:32]));
					compare_field("row_end", 32'(want.row_end), 32'(m_axis_tlast));
					compare_field("row_advance", 32'(want.row_advance), 32'(m_axis_tdata[47:40]));
					results_checked++;
					if (want.row_end)
						row_ends_seen++;
				end
			end

			if (pixel_taken) begin
				nb.frame_start  = s_axis_tuser[0];
				nb.top_left     = s_axis_tdata[31:0];
				nb.top_right    = s_axis_tdata[63:32];
				nb.bottom_left  = s_axis_tdata[95:64];
				nb.bottom_right = s_axis_tdata[127:96];
				expected_pixels.push_back(scale_pixel(nb));
				items_taken++;
			end

			if (reg_written) begin
				case (cfg_index)
					REG_SMOOTH:       model_cfg.smooth       = cfg_data[0];
					REG_PIXEL_FORMAT: model_cfg.pixel_format = cfg_data[0];
					REG_STEP_X:       model_cfg.step_x       = cfg_data;
					REG_STEP_Y:       model_cfg.step_y       = cfg_data;
					REG_ROW_WIDTH:    model_cfg.row_width    = cfg_data[12:0];
					REG_START_X:      model_cfg.start_x      = cfg_data[11:0];
					REG_START_Y:      model_cfg.start_y      = cfg_data[11:0];
					default: ;
				endcase
			end

			if (pixel_taken || result_taken || reg_written)
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	// ------------------------------------------------------------------
	// Sender: offers the oldest pending item at the falling edge. An offered item is
	// held until it is taken; while bursts_on is set it may pause between items.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			send_gap = 0;
		end else begin
			if (s_axis_tvalid && pixel_taken)
				void'(pixels_to_send.pop_front());
			if (s_axis_tvalid && !pixel_taken) begin
				// Still waiting for the scaler to take the current item.
			end else if (send_gap > 0) begin
				s_axis_tvalid <= 1'b0;
				send_gap--;
			end else if (pixels_to_send.size() != 0 && bursts_on && $urandom_range(0, 5) == 0) begin
				s_axis_tvalid <= 1'b0;
				send_gap = $urandom_range(0, 3);
			end else if (pixels_to_send.size() != 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tuser  <= pixels_to_send[0].frame_start;
				s_axis_tdata  <= {pixels_to_send[0].bottom_right, pixels_to_send[0].bottom_left,
					pixels_to_send[0].top_right, pixels_to_send[0].top_left};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: ready at the falling edge, with random bursts of back-pressure and one
	// long hold-off on request, so that the pipeline fills and stalls its input.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap  = 0;
			hold_left = 0;
		end else if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = LONG_HOLD - 1;
			m_axis_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			m_axis_tready <= 1'b0;
			recv_gap--;
		end else if (bursts_on && $urandom_range(0, 4) == 0) begin
			m_axis_tready <= 1'b0;
			recv_gap = $urandom_range(0, 3);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// The run is stuck if nothing at all is taken for this long.
	initial begin
		wait (stall_cycles >= WATCHDOG_LIMIT);
		$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
		$display("bilinear_pixel_scaler_test: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------

	// Writes one register; only called while the scaler is idle.
	task automatic write_reg(input logic [2:0] index, input logic [23:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_setting(input logic smooth, input logic fmt, input logic [23:0] sx,
			input logic [23:0] sy, input logic [12:0] width, input logic [11:0] x0,
			input logic [11:0] y0);
		write_reg(REG_SMOOTH, 24'(smooth));
		write_reg(REG_PIXEL_FORMAT, 24'(fmt));
		write_reg(REG_STEP_X, sx);
		write_reg(REG_STEP_Y, sy);
		write_reg(REG_ROW_WIDTH, 24'(width));
		write_reg(REG_START_X, 24'(x0));
		write_reg(REG_START_Y, 24'(y0));
		settings_used++;
	endtask

	// Waits until every queued item has been taken and every result checked, then lets
	// the pipeline settle before anything touches the registers.
	task automatic wait_until_idle();
		while (pixels_to_send.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (RESULT_LATENCY + 2) @(posedge clk);
	endtask

	task automatic queue_pixel(input logic fs, input logic [31:0] tl, input logic [31:0] tr,
			input logic [31:0] bl, input logic [31:0] br);
		neighbours_t nb;
		nb.frame_start  = fs;
		nb.top_left     = tl;
		nb.top_right    = tr;
		nb.bottom_left  = bl;
		nb.bottom_right = br;
		pixels_to_send.push_back(nb);
	endtask

	// A random neighbour word; now and then every byte is forced to an extreme so that
	// channels see full-scale differences in both directions.
	function automatic logic [31:0] random_word();
		logic [31:0] word;
		word = $urandom;
		if ($urandom_range(0, 3) == 0) begin
			for (int lane = 0; lane < LANES; lane++)
				word[lane*8 +: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
		end
		return word;
	endfunction

	task automatic queue_random_pixels(input int count, input bit restart_first);
		for (int i = 0; i < count; i++)
			queue_pixel((restart_first && i == 0) || $urandom_range(0, 49) == 0,
				random_word(), random_word(), random_word(), random_word());
	endtask

	function automatic logic [23:0] pick_step();
		case ($urandom_range(0, 5))
			0:       return 24'h000000;
			1:       return 24'hffffff;
			2:       return 24'hff0000;
			3:       return STEP_RESET;
			4:       return 24'($urandom_range(1, 24'h02ffff));
			default: return 24'($urandom);
		endcase
	endfunction

	// Mostly short rows so that row ends come often; the extremes now and then.
	function automatic logic [12:0] pick_width();
		case ($urandom_range(0, 9))
			0:       return 13'd0;
			1:       return 13'd4096;
			2:       return 13'h1fff;
			3, 4, 5: return 13'($urandom_range(1, 4));
			6, 7:    return 13'($urandom_range(5, 16));
			8:       return 13'($urandom_range(17, 200));
			default: return 13'($urandom);
		endcase
	endfunction

	function automatic logic [11:0] pick_start();
		case ($urandom_range(0, 3))
			0:       return 12'd0;
			1:       return 12'hfff;
			default: return 12'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------
	initial begin
		int count;
		bursts_on    = 1'b1;
		hold_request = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed items. With the reset defaults both fractions stay zero, so the
		// result is the top-left neighbour.
		queue_pixel(1'b1, 32'h0, 32'h0, 32'h0, 32'h0);
		queue_pixel(1'b0, '1, '1, '1, '1);
		wait_until_idle();

		// Half-pixel horizontal and three-quarter vertical position, three-wide rows.
		// Differences go both ways so that the floor of negative products is seen.
		write_setting(1'b1, FMT_RGBA8888, 24'h008000, 24'h00c000, 13'd3, 12'd3, 12'd5);
		queue_pixel(1'b1, 32'h00000000, 32'hffffffff, 32'hffffffff, 32'h00000000);
		queue_pixel(1'b0, 32'hffffffff, 32'h00000000, 32'h00000000, 32'hffffffff);
		queue_pixel(1'b0, 32'h00ff00ff, 32'hff00ff00, 32'h12345678, 32'h87654321);
		queue_pixel(1'b0, 32'h80808080, 32'h7f7f7f7f, 32'h01010101, 32'hfefefefe);
		wait_until_idle();

		// RGB565 with junk in the upper halves, which must be ignored.
		write_reg(REG_PIXEL_FORMAT, 24'(FMT_RGB565));
		queue_pixel(1'b1, 32'hffff0000, 32'h0000ffff, 32'h0000f800, 32'h000007ff);
		queue_pixel(1'b0, 32'h0000ffe0, 32'h0000f81f, 32'hffff001f, 32'hffff07e0);
		queue_pixel(1'b0, 32'ha5a5ffff, 32'h00000000, 32'hffffffff, 32'h5a5a0000);
		wait_until_idle();

		// Nearest-neighbour copy in both formats.
		write_reg(REG_SMOOTH, 24'd0);
		queue_pixel(1'b0, 32'hffffabcd, 32'h13572468, 32'h0f0f0f0f, 32'hf0f0f0f0);
		wait_until_idle();
		write_reg(REG_PIXEL_FORMAT, 24'(FMT_RGBA8888));
		queue_pixel(1'b0, 32'hdeadbeef, 32'h01234567, 32'h89abcdef, 32'h76543210);
		wait_until_idle();

		// Largest steps and start offsets wrap both advances; a width of zero acts as one.
		write_setting(1'b1, FMT_RGBA8888, 24'hffffff, 24'hffffff, 13'd0, 12'hfff, 12'hfff);
		queue_random_pixels(3, 1'b1);
		wait_until_idle();

		// Zero steps, and a width beyond the limit.
		write_setting(1'b1, FMT_RGBA8888, 24'h000000, 24'h000000, 13'h1fff, 12'd0, 12'd0);
		queue_random_pixels(2, 1'b1);
		wait_until_idle();

		// The largest advance of 255 columns and rows, then a write to a free index.
		write_setting(1'b1, FMT_RGB565, 24'hff0000, 24'hff0000, 13'd2, 12'd7, 12'd9);
		queue_random_pixels(4, 1'b1);
		wait_until_idle();
		write_reg(REG_UNUSED, 24'hffffff);
		queue_random_pixels(1, 1'b0);
		wait_until_idle();

		// Random settings, each followed by a batch of random items.
		for (int phase = 0; phase < 14; phase++) begin
			bursts_on = ($urandom_range(0, 3) != 0);
			write_setting(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_step(),
				pick_step(), pick_width(), pick_start(), pick_start());
			count = $urandom_range(90, 130);
			if (phase == 2) begin
				// Hold results back for a long stretch while items keep coming.
				queue_random_pixels(count, 1'b1);
				@(posedge clk);
				hold_request = 1'b1;
			end else if (phase == 5) begin
				// The sender stops until every result so far has come back.
				queue_random_pixels(count / 2, 1'b1);
				while (pixels_to_send.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0)
					@(posedge clk);
				queue_random_pixels(count - count / 2, 1'b0);
			end else begin
				queue_random_pixels(count, 1'b1);
			end
			wait_until_idle();
		end

		// Final stretch at full rate on both sides.
		bursts_on = 1'b0;
		write_setting(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_step(),
			pick_step(), 13'($urandom_range(1, 8)), pick_start(), pick_start());
		queue_random_pixels(150, 1'b1);
		wait_until_idle();

		$display("Checked %0d results (%0d row ends) for %0d items over %0d register settings,",
			results_checked, row_ends_seen, items_taken, settings_used);
		$display("in both pixel formats, both modes, and with random and long output stalls.");
		if (error_count == 0)
			$display("bilinear_pixel_scaler_test: PASS");
		else
			$display("bilinear_pixel_scaler_test: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/bps_pkg.sv
rtl/bps_pos.sv
rtl/bps_lane.sv
rtl/bps_merge.sv
rtl/bilinear_pixel_scaler.sv
sim/bilinear_pixel_scaler_test.sv
